@@ rtl/core/pip_pkg.sv @@
`timescale 1ns / 1ps
package pip_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_READ,
    S_LOAD,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_EVAL
  } state_t;

  typedef struct packed {
    logic store_full;
    logic inside_res;
  } result_t;

endpackage

@@ rtl/core/pip_vstore.sv @@
`timescale 1ns / 1ps
module pip_vstore #(
  parameter int DEPTH = 512,
  parameter int W     = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/pip_mul.sv @@
`timescale 1ns / 1ps
module pip_mul #(
  parameter int CB = 20
) (
  input  logic                   clk,
  input  logic signed [CB:0]     a,
  input  logic signed [CB:0]     b,
  output logic signed [2*CB+1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ rtl/core/point_in_polygon_test.sv @@
`timescale 1ns / 1ps
// Point-in-polygon test with an internal vertex store.
// Input channel s_*: operation, point_x, point_y in tdata. Clear empties the
// vertex list, append adds one vertex, query tests a point against the closed
// polygon. Output channel m_*: one item per input item, inside_res and
// store_full in tdata.
// Clear and append: the result is valid in the cycle after the input is accepted.
// Query over n vertices: the edges are walked in order, ending early when the point
// lies on an edge (empty list: result in the cycle after acceptance). Each
// edge takes a store read plus four passes through the single shared
// (CB+1)x(CB+1) multiplier (two cross-product terms, the crossing numerator,
// and the scaled point offset); no divider is used, the truncated crossing x
// is compared by multiplying through by the edge height.
// One item is worked at a time; s_tready is high only in idle with the output
// register free or being taken. A stalled output holds its item and blocks
// new input.
// Reset clears the vertex count and the output valid; store contents are not
// cleared and are only read below the count.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 512,
  parameter int COORD_BITS   = 20
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // [1:0] operation, [CB+1:2] point_x, [2CB+1:CB+2] point_y, zero pad
  input  logic [((2*COORD_BITS+2+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // [0] inside_res, [1] store_full, zero pad
  output logic [7:0] m_tdata
);

  localparam int CB = COORD_BITS;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int PW = 2*CB + 2;
  localparam int XW = 2*CB + 3;

  pip_pkg::state_t state, state_next;
  pip_pkg::result_t res;

  logic [CW-1:0] count, idx;
  logic [CB-1:0] px, py, ax, ay, bx, by, fx, fy;
  logic [1:0]    op_in;
  logic [CB-1:0] in_x, in_y;
  logic          accept;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_raddr;
  logic [2*CB-1:0] mem_rdata;

  logic signed [CB:0] mul_a, mul_b;
  logic signed [PW-1:0] prod, lhs, nval;
  logic          on_edge, crossing;

  logic [CB-1:0] lx, ly, hx, hy;
  logic signed [CB:0] dy;
  logic signed [XW-1:0] td_x, n_x;

  assign op_in  = s_tdata[1:0];
  assign in_x   = s_tdata[CB+1:2];
  assign in_y   = s_tdata[2*CB+1:CB+2];
  assign s_tready = (state == pip_pkg::S_IDLE) && (!m_tvalid || m_tready);
  assign accept = s_tvalid && s_tready;
  assign m_tdata = {6'd0, res};

  assign mem_we = accept && (op_in == pip_pkg::OP_APPEND) &&
                  (count < CW'(MAX_VERTICES));

  pip_vstore #(.DEPTH(MAX_VERTICES), .W(2*CB)) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(count[AW-1:0]),
    .wdata({in_y, in_x}),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    if (ay < by) begin
      lx = ax; ly = ay; hx = bx; hy = by;
    end else begin
      lx = bx; ly = by; hx = ax; hy = ay;
    end
  end

  assign dy = $signed({1'b0, hy}) - $signed({1'b0, ly});

  always_comb begin
    unique case (state)
      pip_pkg::S_M0: begin
        mul_a = $signed({1'b0, ax}) - $signed({1'b0, px});
        mul_b = $signed({1'b0, by}) - $signed({1'b0, py});
      end
      pip_pkg::S_M1: begin
        mul_a = $signed({1'b0, ay}) - $signed({1'b0, py});
        mul_b = $signed({1'b0, bx}) - $signed({1'b0, px});
      end
      pip_pkg::S_M2: begin
        mul_a = $signed({1'b0, hx}) - $signed({1'b0, lx});
        mul_b = $signed({1'b0, py}) - $signed({1'b0, ly});
      end
      default: begin
        mul_a = $signed({1'b0, px}) - $signed({1'b0, lx});
        mul_b = dy;
      end
    endcase
  end

  pip_mul #(.CB(CB)) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (prod)
  );

  // px - lx < trunc(n / dy), dy > 0
  assign td_x = XW'(prod);
  assign n_x  = XW'(nval);
  assign crossing = (ay != by) && (py >= ly) && (py < hy) &&
                    ((nval >= 0) ? (td_x + XW'(dy) <= n_x) : (td_x < n_x));

  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_raddr  = idx[AW-1:0];
    unique case (state)
      pip_pkg::S_IDLE: begin
        if (accept && (op_in == pip_pkg::OP_QUERY) && (count != '0)) begin
          mem_re     = 1'b1;
          mem_raddr  = '0;
          state_next = pip_pkg::S_FIRST;
        end
      end
      pip_pkg::S_FIRST: state_next = pip_pkg::S_READ;
      pip_pkg::S_READ: begin
        mem_re     = idx < count;
        state_next = pip_pkg::S_LOAD;
      end
      pip_pkg::S_LOAD: state_next = pip_pkg::S_M0;
      pip_pkg::S_M0:   state_next = pip_pkg::S_M1;
      pip_pkg::S_M1:   state_next = pip_pkg::S_M2;
      pip_pkg::S_M2:   state_next = pip_pkg::S_M3;
      pip_pkg::S_M3:   state_next = pip_pkg::S_EVAL;
      pip_pkg::S_EVAL: begin
        if (on_edge || idx == count) begin
          state_next = pip_pkg::S_IDLE;
        end else begin
          state_next = pip_pkg::S_READ;
        end
      end
      default: state_next = pip_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pip_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        unique case (op_in)
          pip_pkg::OP_CLEAR: begin
            count    <= '0;
            m_tvalid <= 1'b1;
          end
          pip_pkg::OP_APPEND: begin
            if (mem_we) begin
              count <= count + CW'(1);
            end
            m_tvalid <= 1'b1;
          end
          pip_pkg::OP_QUERY: m_tvalid <= (count == '0);
          default: m_tvalid <= 1'b1;
        endcase
      end else if (state == pip_pkg::S_EVAL && (on_edge || idx == count)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px  <= in_x;
      py  <= in_y;
      res <= '{store_full: (op_in == pip_pkg::OP_APPEND) && !mem_we,
               inside_res: 1'b0};
    end
    unique case (state)
      pip_pkg::S_FIRST: begin
        ax  <= mem_rdata[CB-1:0];
        ay  <= mem_rdata[2*CB-1:CB];
        fx  <= mem_rdata[CB-1:0];
        fy  <= mem_rdata[2*CB-1:CB];
        idx <= CW'(1);
      end
      pip_pkg::S_LOAD: begin
        if (idx < count) begin
          bx <= mem_rdata[CB-1:0];
          by <= mem_rdata[2*CB-1:CB];
        end else begin
          bx <= fx;
          by <= fy;
        end
      end
      pip_pkg::S_M1: lhs <= prod;
      pip_pkg::S_M2: begin
        on_edge <= (lhs == prod) &&
                   (px >= ((ax < bx) ? ax : bx)) && (px <= ((ax > bx) ? ax : bx)) &&
                   (py >= ((ay < by) ? ay : by)) && (py <= ((ay > by) ? ay : by));
      end
      pip_pkg::S_M3: nval <= prod;
      pip_pkg::S_EVAL: begin
        if (on_edge) begin
          res.inside_res <= 1'b1;
        end else if (crossing) begin
          res.inside_res <= !res.inside_res;
        end
        ax  <= bx;
        ay  <= by;
        idx <= idx + CW'(1);
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/pip_checker.sv @@
`timescale 1ns / 1ps
module pip_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

  a_no_accept_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while result stalled");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_exclusive_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]) && (m_tdata[7:2] == 6'd0))
    else $error("bad result item");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
